/* hw/rtl/ssk_pkg.sv */
// shared types, widths and gap helpers for the shell sort core
// no dependencies; imported by ssk_store and shell_sort_knuth_gaps_core
`timescale 1ns / 1ps

package ssk_pkg;

  localparam int DATA_W       = 32;
  localparam int GAP_W        = 6;
  localparam int CAPACITY_DEF = 64;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_GETV,
    ST_CMP,
    ST_PUT,
    ST_OCAP,
    ST_OSEND
  } sort_state_t;

  // (x) / 9 for x below 72, by multiply with 57 and shift by 9
  function automatic logic [2:0] div9(input logic [6:0] x);
    logic [12:0] prod;
    prod = 13'(x) * 13'd57;
    return prod[11:9];
  endfunction

  // first member of 1, 4, 13, ... not below the limit
  function automatic logic [GAP_W-1:0] start_gap(input logic [2:0] limit);
    logic [GAP_W-1:0] g;
    if (limit <= 3'd1) begin
      g = GAP_W'(1);
    end else if (limit <= 3'd4) begin
      g = GAP_W'(4);
    end else begin
      g = GAP_W'(13);
    end
    return g;
  endfunction

  // gap divided by 3 over the members of the series
  function automatic logic [GAP_W-1:0] next_gap(input logic [GAP_W-1:0] g);
    logic [GAP_W-1:0] r;
    case (g)
      GAP_W'(13): r = GAP_W'(4);
      GAP_W'(4):  r = GAP_W'(1);
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/ssk_store.sv */
// element store: one write port, one read port, registered read data
// depends on ssk_pkg for the word width
`timescale 1ns / 1ps

module ssk_store
  import ssk_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/shell_sort_knuth_gaps_core.sv */
// Shell sort core (gap series h = 3h + 1), top level with the sort sequencer
// depends on ssk_pkg and ssk_store
`timescale 1ns / 1ps

// Words are loaded one per cycle until a word marked last_in, or until the
// store holds CAPACITY words. The set is then sorted ascending in place in a
// single-port-read, single-port-write memory: each insertion step fetches its
// element and then its first neighbor one gap back, then compares and moves
// one neighbor at a time until the element lands; each gap pass opens with a
// setup state. Each sorted word is fetched and captured into the output
// register, then held there while out_stall is high; the next word is fetched
// only after the one before is taken. The final word has last_out set; in_stall
// stays high from the last loaded word until that final word is taken. The
// store needs no clearing after reset.
module shell_sort_knuth_gaps_core
  import ssk_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     last_out
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > GAP_W) ? CW : GAP_W;

  sort_state_t state, state_next;
  logic [IW-1:0]     count, count_next;
  logic [IW-1:0]     n, n_next;
  logic [GAP_W-1:0]  gap, gap_next;
  logic [IW-1:0]     i, i_next;
  logic [IW-1:0]     j, j_next;
  logic [IW-1:0]     k, k_next;
  logic [DATA_W-1:0] v, v_next;
  logic              out_valid_next;
  logic [DATA_W-1:0] sorted_value_next;
  logic              last_out_next;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [IW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  logic [IW-1:0] gap_ext;
  logic [IW-1:0] j_back;
  logic [IW-1:0] i_inc;
  logic [IW-1:0] k_inc;

  assign gap_ext = IW'(gap);
  assign j_back  = j - gap_ext;
  assign i_inc   = i + IW'(1);
  assign k_inc   = k + IW'(1);

  ssk_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr[AW-1:0]),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      gap       <= GAP_W'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      gap       <= gap_next;
      out_valid <= out_valid_next;
    end
  end

  // indexes and payload
  always_ff @(posedge clk) begin
    n            <= n_next;
    i            <= i_next;
    j            <= j_next;
    k            <= k_next;
    v            <= v_next;
    sorted_value <= sorted_value_next;
    last_out     <= last_out_next;
  end

  assign in_stall = (state != ST_LOAD);

  // sequencer: load, gapped insertion passes, drain
  always_comb begin
    state_next        = state;
    count_next        = count;
    n_next            = n;
    gap_next          = gap;
    i_next            = i;
    j_next            = j;
    k_next            = k;
    v_next            = v;
    out_valid_next    = out_valid;
    sorted_value_next = sorted_value;
    last_out_next     = last_out;
    we                = 1'b0;
    waddr             = j;
    wdata             = v;
    raddr             = '0;

    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          we    = 1'b1;
          waddr = count;
          wdata = value;
          if (last_in || (count == IW'(CAPACITY - 1))) begin
            n_next     = count + IW'(1);
            count_next = '0;
            gap_next   = start_gap(div9(7'(count)));
            state_next = ST_INIT;
          end else begin
            count_next = count + IW'(1);
          end
        end
      end

      ST_INIT: begin
        if (gap == '0) begin
          k_next     = '0;
          raddr      = '0;
          state_next = ST_OCAP;
        end else if (gap_ext < n) begin
          i_next     = gap_ext;
          j_next     = gap_ext;
          raddr      = gap_ext;
          state_next = ST_GETV;
        end else begin
          gap_next = next_gap(gap);
        end
      end

      // element in hand, fetch the neighbor one gap back
      ST_GETV: begin
        v_next     = rdata;
        raddr      = j_back;
        state_next = ST_CMP;
      end

      ST_CMP: begin
        we = 1'b1;
        if ($signed(v) < $signed(rdata)) begin
          // shift the neighbor up one gap
          wdata  = rdata;
          j_next = j_back;
          if (j_back >= gap_ext) begin
            raddr = j_back - gap_ext;
          end else begin
            state_next = ST_PUT;
          end
        end else begin
          // element lands here, go to the next one or end the gap pass
          wdata = v;
          if (i_inc < n) begin
            i_next     = i_inc;
            j_next     = i_inc;
            raddr      = i_inc;
            state_next = ST_GETV;
          end else begin
            gap_next   = next_gap(gap);
            state_next = ST_INIT;
          end
        end
      end

      ST_PUT: begin
        we    = 1'b1;
        wdata = v;
        if (i_inc < n) begin
          i_next     = i_inc;
          j_next     = i_inc;
          raddr      = i_inc;
          state_next = ST_GETV;
        end else begin
          gap_next   = next_gap(gap);
          state_next = ST_INIT;
        end
      end

      // capture the fetched word into the output register
      ST_OCAP: begin
        sorted_value_next = rdata;
        last_out_next     = (k_inc == n);
        out_valid_next    = 1'b1;
        state_next        = ST_OSEND;
      end

      ST_OSEND: begin
        if (!out_stall) begin
          out_valid_next = 1'b0;
          if (last_out) begin
            gap_next   = GAP_W'(1);
            state_next = ST_LOAD;
          end else begin
            k_next     = k_inc;
            raddr      = k_inc;
            state_next = ST_OCAP;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule
